>>> rtl/line_segment_grouping_defines.svh
// Assertion macros for the line segment grouping block.
`ifndef LINE_SEGMENT_GROUPING_DEFINES_SVH
`define LINE_SEGMENT_GROUPING_DEFINES_SVH
`ifndef SYNTH
`define LSG_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LSG_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LSG_ASSERT_IMP(label, clk, rst_n, a, c)
`define LSG_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/lsg_pkg.sv
// Shared types and constants for the line segment grouping block.
`default_nettype none
package lsg_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS = 12;
  localparam int IDX_BITS = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS = $clog2(MAX_SEGMENTS + 1);
  localparam int SUM_BITS = COORD_BITS + IDX_BITS + 1;
  localparam int QDEPTH = 2;
  localparam logic [11:0] GROUP_DISTANCE_RESET = 12'd30;

  typedef struct packed {
    logic [11:0] first_x;
    logic [11:0] first_y;
    logic [11:0] second_x;
    logic [11:0] second_y;
    logic        final_segment;
  } in_item_t;

  typedef struct packed {
    logic [11:0] top_x;
    logic [11:0] top_y;
    logic [11:0] bottom_x;
    logic [11:0] bottom_y;
    logic        final_group;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } seg_t;

  // Command from the front to the back: store a segment, maybe start grouping.
  typedef struct packed {
    seg_t seg;
    logic last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED, ST_SCAN, ST_DIV, ST_EMIT
  } bk_state_t;
endpackage
`default_nettype wire

>>> rtl/lsg_front.sv
// Front end: input handshake, coordinate masking and a short command queue.
`default_nettype none
module lsg_front import lsg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_take,
  output cmd_t          cmd
);
  cmd_t q_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic push, pop;
  cmd_t c;

  always_comb begin
    c.seg.ax = in_data.first_x[COORD_BITS-1:0];
    c.seg.ay = in_data.first_y[COORD_BITS-1:0];
    c.seg.bx = in_data.second_x[COORD_BITS-1:0];
    c.seg.by = in_data.second_y[COORD_BITS-1:0];
    c.last = in_data.final_segment;
  end

  assign in_stall = (cnt_r == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop = cmd_valid && cmd_take;
  assign cmd = q_r[rp_r];
  assign cnt_nxt = cnt_r + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule
`default_nettype wire

>>> rtl/lsg_back.sv
// Back end: segment memory, greedy grouping scan, averaging and result register.
`default_nettype none
module lsg_back import lsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [11:0] join_dist,
  input  wire logic        cmd_valid,
  output logic             cmd_take,
  input  wire cmd_t        cmd,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);
  seg_t mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] unused_r, unused_nxt;
  bk_state_t st_r, st_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CNT_BITS-1:0] members_r, members_nxt;
  logic [SUM_BITS-1:0] sum_r [4];
  logic [SUM_BITS-1:0] sum_nxt [4];
  seg_t seed_r, rd_r;
  logic [IDX_BITS-1:0] rd_addr;
  logic [SUM_BITS-1:0] rem_r [4];
  logic [SUM_BITS-1:0] rem_nxt [4];
  logic [COORD_BITS-1:0] quo_r [4];
  logic [COORD_BITS-1:0] quo_nxt [4];
  logic [$clog2(COORD_BITS+1)-1:0] bit_r, bit_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r;
  logic any_left_r, any_left_nxt;
  logic mem_we;
  logic store_ok;
  logic [COORD_BITS:0] ms, mc;
  logic [COORD_BITS-1:0] d0, d1, d2;
  logic near;
  logic [COORD_BITS-1:0] ord [4];
  logic [SUM_BITS+COORD_BITS-1:0] trial [4];

  function automatic logic [COORD_BITS-1:0] adiff(logic [COORD_BITS-1:0] a,
                                                  logic [COORD_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // The read address follows the next scan index, so the registered read holds the current entry.
  // A segment written in the same cycle is forwarded, so a set whose only
  // segment is the final one reads the new entry and not stale contents.
  assign rd_addr = (st_nxt == ST_SEED) ? i_nxt[IDX_BITS-1:0] : j_nxt[IDX_BITS-1:0];
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[IDX_BITS-1:0]] <= cmd.seg;
    if (mem_we && rd_addr == count_r[IDX_BITS-1:0]) rd_r <= cmd.seg;
    else rd_r <= mem[rd_addr];
  end

  assign ms = ({1'b0, seed_r.ax} + {1'b0, seed_r.bx}) >> 1;
  assign mc = ({1'b0, rd_r.ax} + {1'b0, rd_r.bx}) >> 1;
  assign d0 = adiff(ms[COORD_BITS-1:0], mc[COORD_BITS-1:0]);
  assign d1 = adiff(seed_r.ax, rd_r.ax);
  assign d2 = adiff(seed_r.bx, rd_r.bx);
  assign near = ({4'd0, d0} < 16'(join_dist)) || ({4'd0, d1} < 16'(join_dist))
             || ({4'd0, d2} < 16'(join_dist));

  always_comb begin
    if (rd_r.ay < rd_r.by) begin
      ord[0] = rd_r.ax; ord[1] = rd_r.ay; ord[2] = rd_r.bx; ord[3] = rd_r.by;
    end else begin
      ord[0] = rd_r.bx; ord[1] = rd_r.by; ord[2] = rd_r.ax; ord[3] = rd_r.ay;
    end
  end

  assign store_ok = (count_r < CNT_BITS'(MAX_SEGMENTS));

  always_comb begin
    st_nxt = st_r;
    count_nxt = count_r;
    unused_nxt = unused_r;
    i_nxt = i_r;
    j_nxt = j_r;
    members_nxt = members_r;
    sum_nxt = sum_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    bit_nxt = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    any_left_nxt = any_left_r;
    cmd_take = 1'b0;
    mem_we = 1'b0;
    for (int k = 0; k < 4; k++) trial[k] = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          if (store_ok) begin
            mem_we = 1'b1;
            unused_nxt[count_r[IDX_BITS-1:0]] = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (cmd.last) begin
            i_nxt = '0;
            st_nxt = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        // rd_r holds entry i.
        if (i_r == count_r) begin
          unused_nxt = '0;
          count_nxt = '0;
          st_nxt = ST_IDLE;
        end else if (!unused_r[i_r[IDX_BITS-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          unused_nxt[i_r[IDX_BITS-1:0]] = 1'b0;
          for (int k = 0; k < 4; k++) sum_nxt[k] = SUM_BITS'(ord[k]);
          members_nxt = CNT_BITS'(1);
          j_nxt = i_r + 1'b1;
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_r == count_r) begin
          for (int k = 0; k < 4; k++) rem_nxt[k] = sum_r[k];
          bit_nxt = ($clog2(COORD_BITS+1))'(COORD_BITS);
          st_nxt = ST_DIV;
        end else begin
          if (unused_r[j_r[IDX_BITS-1:0]] && near) begin
            unused_nxt[j_r[IDX_BITS-1:0]] = 1'b0;
            for (int k = 0; k < 4; k++) sum_nxt[k] = sum_r[k] + SUM_BITS'(ord[k]);
            members_nxt = members_r + 1'b1;
          end
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle; quotients fit the coordinate.
        if (bit_r == '0) begin
          any_left_nxt = 1'b0;
          for (int k = 0; k < MAX_SEGMENTS; k++)
            if (k > int'(i_r) && k < int'(count_r) && unused_r[k]) any_left_nxt = 1'b1;
          st_nxt = ST_EMIT;
        end else begin
          for (int k = 0; k < 4; k++) begin
            trial[k] = (SUM_BITS+COORD_BITS)'(members_r) << (bit_r - 1'b1);
            if ((SUM_BITS+COORD_BITS)'(rem_r[k]) >= trial[k]) begin
              rem_nxt[k] = rem_r[k] - trial[k][SUM_BITS-1:0];
              quo_nxt[k][bit_r - 1'b1] = 1'b1;
            end else begin
              quo_nxt[k][bit_r - 1'b1] = 1'b0;
            end
          end
          bit_nxt = bit_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
          if (!any_left_r) begin
            unused_nxt = '0;
            count_nxt = '0;
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_SEED;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      unused_r <= '0;
      out_valid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      unused_r <= unused_nxt;
      out_valid_r <= out_valid_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
    members_r <= members_nxt;
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    bit_r <= bit_nxt;
    any_left_r <= any_left_nxt;
    if (st_r == ST_SEED && i_r != count_r) seed_r <= rd_r;
    if (st_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_r.top_x <= 12'(quo_r[0]);
      out_r.top_y <= 12'(quo_r[1]);
      out_r.bottom_x <= 12'(quo_r[2]);
      out_r.bottom_y <= 12'(quo_r[3]);
      out_r.final_group <= !any_left_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
`default_nettype wire

>>> rtl/line_segment_grouping.sv
// Top level of the line segment grouping block.
//
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid/in_stall   | in_item_t (two endpoints, final flag)
//  out_     | output    | out_valid/out_stall | out_item_t (averaged segment, final flag)
//  cfg_     | input     | cfg_we              | cfg_data
//
// A non-final segment transfer is stored by the back end from the queue.
// A final segment runs the grouping: for each group the scan reads every later
// stored segment in turn through the single read port of the segment memory,
// then a bit-serial division averages the group. The front queue takes up to
// two segments while the back end works and then stalls the input.
// Reset is synchronous and active low; it clears the count, marks and queue.
// A stalled output holds its result, and the back end waits before emitting.
`default_nettype none
`include "line_segment_grouping_defines.svh"
module line_segment_grouping import lsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_data
);
  logic [11:0] dist_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // The grouping threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= GROUP_DISTANCE_RESET;
    end else if (cfg_we) begin
      dist_r <= cfg_data;
    end
  end

  lsg_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  lsg_back u_back (
    .clk, .rst_n, .join_dist(dist_r), .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

  // A command is only taken when one is queued.
  `LSG_ASSERT_IMP(a_take_valid, clk, rst_n, cmd_take, cmd_valid)
  // A stalled result stays valid in the next cycle.
  `LSG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

>>> dv/line_segment_grouping_tb.sv
// Self-checking testbench for the line segment grouping block.
`default_nettype none
module line_segment_grouping_tb import lsg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts averaged groups from loaded segments and checks each result transfer.
  class group_scoreboard;
    seg_t        held_segs[$];
    logic [11:0] join_dist;
    out_item_t   pending_groups[$];
    int          error_count;
    int          group_total;
    int          set_total;

    function void note_segment(in_item_t it);
      seg_t s;
      bit   used [MAX_SEGMENTS];
      int   n;
      int   members;
      logic [31:0] sum [4];
      out_item_t g;
      out_item_t made[$];
      s.ax = it.first_x;
      s.ay = it.first_y;
      s.bx = it.second_x;
      s.by = it.second_y;
      // A full store drops the segment; a final flag still starts grouping.
      if (held_segs.size() < MAX_SEGMENTS) held_segs = {held_segs, s};
      if (!it.final_segment) return;
      n = held_segs.size();
      foreach (used[k]) used[k] = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (used[i]) continue;
        used[i] = 1'b1;
        members = 1;
        for (int q = 0; q < 4; q++) sum[q] = 0;
        add_ordered(held_segs[i], sum);
        for (int j = i + 1; j < n; j++) begin
          if (!used[j] && near(held_segs[i], held_segs[j])) begin
            used[j] = 1'b1;
            add_ordered(held_segs[j], sum);
            members++;
          end
        end
        g.top_x = 12'(sum[0] / members);
        g.top_y = 12'(sum[1] / members);
        g.bottom_x = 12'(sum[2] / members);
        g.bottom_y = 12'(sum[3] / members);
        g.final_group = 1'b0;
        made = {made, g};
      end
      made[made.size()-1].final_group = 1'b1;
      foreach (made[k]) pending_groups = {pending_groups, made[k]};
      held_segs.delete();
      set_total++;
    endfunction

    function void add_ordered(seg_t s, ref logic [31:0] sum [4]);
      if (s.ay < s.by) begin
        sum[0] += s.ax; sum[1] += s.ay; sum[2] += s.bx; sum[3] += s.by;
      end else begin
        sum[0] += s.bx; sum[1] += s.by; sum[2] += s.ax; sum[3] += s.ay;
      end
    endfunction

    function bit near(seg_t a, seg_t b);
      int ma;
      int mb;
      ma = (int'(a.ax) + int'(a.bx)) / 2;
      mb = (int'(b.ax) + int'(b.bx)) / 2;
      return coord_gap(ma, mb) < join_dist || coord_gap(a.ax, b.ax) < join_dist
          || coord_gap(a.bx, b.bx) < join_dist;
    endfunction

    function int coord_gap(int a, int b);
      return a > b ? a - b : b - a;
    endfunction

    function void check_group(out_item_t got);
      out_item_t exp;
      if (pending_groups.size() == 0) begin
        $error("unexpected group result %h", got);
        error_count++;
        return;
      end
      exp = pending_groups.pop_front();
      group_total++;
      if (got.top_x !== exp.top_x) begin
        $error("top_x expected %0d actual %0d", exp.top_x, got.top_x); error_count++;
      end
      if (got.top_y !== exp.top_y) begin
        $error("top_y expected %0d actual %0d", exp.top_y, got.top_y); error_count++;
      end
      if (got.bottom_x !== exp.bottom_x) begin
        $error("bottom_x expected %0d actual %0d", exp.bottom_x, got.bottom_x);
        error_count++;
      end
      if (got.bottom_y !== exp.bottom_y) begin
        $error("bottom_y expected %0d actual %0d", exp.bottom_y, got.bottom_y);
        error_count++;
      end
      if (got.final_group !== exp.final_group) begin
        $error("final_group expected %0b actual %0b", exp.final_group, got.final_group);
        error_count++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [11:0] cfg_data;

  group_scoreboard sb;
  int  idle_cycles;
  bit  hold_output;     // forces a long receiver hold-off
  bit  stall_quiet;     // no random stalls during this phase
  int  sent_total;

  line_segment_grouping u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every transfer is observed at the rising edge, where inputs are stable
  // because the drivers only change them at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_segment(in_data);
      if (out_valid && !out_stall) sb.check_group(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver stall pattern: a bursty random duty cycle, with the option of a
  // forced long hold-off so the block backs up into its input channel.
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) out_stall <= 1'b1;
      else if (stall_quiet) out_stall <= 1'b0;
      else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one segment and holds it until the block takes it.
  task automatic send_segment(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  // Bursts of back-to-back items separated by random gaps.
  int burst_left;
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic wait_all_groups();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_groups.size() != 0) @(negedge clk);
  endtask

  // Only legal while nothing is in flight; the extra cycles cover a store.
  task automatic write_distance(logic [11:0] d);
    wait_all_groups();
    repeat (20) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= d;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.join_dist = d;
  endtask

  function automatic in_item_t rand_segment(bit fin, int spread);
    in_item_t it;
    int base;
    base = $urandom_range(0, 4095);
    it.first_x  = 12'((base + $urandom_range(0, spread)) % 4096);
    it.second_x = 12'((base + $urandom_range(0, spread)) % 4096);
    it.first_y  = 12'($urandom_range(0, 4095));
    it.second_y = ($urandom_range(0, 7) == 0) ? it.first_y : 12'($urandom_range(0, 4095));
    it.final_segment = fin;
    return it;
  endfunction

  // Sends a whole set of n segments, the last one flagged as final.
  task automatic send_set(int n, int spread, bit paced);
    for (int k = 0; k < n; k++) begin
      if (paced) pace_sender();
      send_segment(rand_segment(k == n - 1, spread));
    end
  endtask

  function automatic in_item_t seg_of(int ax, int ay, int bx, int by, bit fin);
    in_item_t it;
    it.first_x = 12'(ax); it.first_y = 12'(ay);
    it.second_x = 12'(bx); it.second_y = 12'(by);
    it.final_segment = fin;
    return it;
  endfunction

  initial begin
    int wait_cycles;
    sb = new();
    sb.join_dist = GROUP_DISTANCE_RESET;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_output = 1'b0;
    stall_quiet = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset distance, a lone final segment, extremes of every field,
    // equal y ordering, and near/far neighbors on midpoint and on each end.
    send_segment(seg_of(0, 0, 0, 0, 1));
    send_segment(seg_of(4095, 4095, 4095, 4095, 1));
    send_segment(seg_of(100, 50, 200, 50, 0));
    send_segment(seg_of(110, 900, 190, 10, 0));
    send_segment(seg_of(129, 10, 4000, 5, 0));
    send_segment(seg_of(3000, 7, 230, 7, 0));
    send_segment(seg_of(2000, 1, 2100, 2, 0));
    send_segment(seg_of(4095, 0, 0, 4095, 0));
    send_segment(seg_of(0, 4095, 4095, 0, 0));
    send_segment(seg_of(2047, 2730, 2048, 1365, 1));
    wait_all_groups();

    // The test writes no zero distance; the smallest and largest nonzero
    // thresholds bracket the grouping behavior.
    write_distance(12'd1);
    send_segment(seg_of(500, 1, 500, 2, 0));
    send_segment(seg_of(500, 3, 500, 4, 0));
    send_segment(seg_of(501, 3, 501, 4, 1));
    write_distance(12'd4095);
    send_segment(seg_of(0, 9, 4095, 8, 0));
    send_segment(seg_of(4095, 5, 0, 6, 0));
    send_segment(seg_of(17, 2, 33, 2, 1));

    // A full store: 64 segments and a dropped 65th that still starts grouping.
    write_distance(12'd60);
    stall_quiet = 1'b1;
    send_set(65, 4095, 1'b0);
    stall_quiet = 1'b0;

    // Backpressure: the receiver holds off while the sender keeps offering
    // several small sets, so the output and then the input queue fill up.
    fork
      begin
        hold_output = 1'b1;
        wait_cycles = 0;
        while (wait_cycles < 1500) begin
          @(negedge clk);
          wait_cycles++;
        end
        hold_output = 1'b0;
      end
      for (int s = 0; s < 6; s++) send_set(3, 4095, 1'b0);
    join
    wait_all_groups();

    // Random sets: mostly small sizes, tight or loose clustering, with the
    // threshold moved between phases and a rare full-size set.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_distance(GROUP_DISTANCE_RESET);
        1: write_distance(12'($urandom_range(1, 4095)));
        2: write_distance(12'd4095);
        3: write_distance(12'd1);
        default: write_distance(12'($urandom_range(1, 300)));
      endcase
      while (sent_total < 110 + phase * 85) begin
        if ($urandom_range(0, 40) == 0) send_set(MAX_SEGMENTS, 400, 1'b1);
        else send_set($urandom_range(1, 8), $urandom_range(0, 1) ? 60 : 4095, 1'b1);
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_groups.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d segments in %0d sets, %0d averaged groups checked.",
             sent_total, sb.set_total, sb.group_total);
    $display("Thresholds from 1 to 4095, a full store with a dropped segment, long hold-off.");
    if (sb.error_count == 0 && sb.pending_groups.size() == 0 && wait_cycles < WATCHDOG_LIMIT)
    begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
